// File: rtl/huffman_tree_decoder_macros.svh
// ----------------------------------------------------------------------------
// Huffman tree decoder assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_DECODER_MACROS_SVH
`define HUFFMAN_TREE_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HFD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hfd assertion failed");

// Next-cycle implication, disabled during reset.
`define HFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hfd assertion failed");

`endif

// File: rtl/hfd_pkg.sv
// ----------------------------------------------------------------------------
// Huffman tree decoder package
// Item and configuration types, command codes and sequencer states.
// ----------------------------------------------------------------------------
package hfd_pkg;

    localparam int BYTE_BITS = 8;

    localparam logic CMD_ENTRY = 1'b0;
    localparam logic CMD_CODE  = 1'b1;

    localparam logic CFG_SYMBOL_COUNT = 1'b0;
    localparam logic CFG_TOTAL_BITS   = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  symbol;
        logic [31:0] frequency;
        logic [7:0]  code_byte;
    } item_t;

    typedef struct packed {
        logic [8:0]  symbol_count;
        logic [31:0] total_bits;
    } cfg_t;

    typedef enum logic {
        PH_LOAD,
        PH_DECODE
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_PUSH_CMP,
        ST_PUSH_END,
        ST_BUILD,
        ST_POP_TOP,
        ST_POP_LAST,
        ST_POP_GOT,
        ST_POP_CHK,
        ST_POP_L,
        ST_POP_R,
        ST_POP_CMP,
        ST_POP_END,
        ST_BIT,
        ST_CHILD,
        ST_SYM
    } state_t;

endpackage

// File: rtl/huffman_tree_decoder.sv
// Load: each entry passes the front queue and then sifts up the heap; the last entry
// also starts the tree build.
// Build: N-1 merges, each two pops and a push.
// Decode: a code byte is walked one bit at a time through the one-read tree and symbol
// memories, and the walk takes no new byte until it is through with the last one.
// Reset: synchronous active-low aresetn returns to the load phase; memories are not cleared.
// ----------------------------------------------------------------------------
// Huffman tree decoder
// Loads symbol/frequency pairs, builds the code tree through a min-heap and
// walks code bytes MSB first, emitting one item per decoded symbol.
// ----------------------------------------------------------------------------
module huffman_tree_decoder #(
    parameter int MAX_SYMBOLS = 256,
    parameter int FREQ_WIDTH  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // input item channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_symbol,
    input  logic [31:0] s_frequency,
    input  logic [7:0]  s_code_byte,
    // result item channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_symbol,
    output logic        m_last_of_item,
    output logic        m_stream_done
);

    hfd_pkg::cfg_t  cfg_reg;
    hfd_pkg::item_t s_item;
    hfd_pkg::item_t q_item;
    logic           q_valid, q_ready;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.symbol_count <= 9'd1;
            cfg_reg.total_bits   <= 32'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                hfd_pkg::CFG_SYMBOL_COUNT: cfg_reg.symbol_count <= cfg_data[8:0];
                hfd_pkg::CFG_TOTAL_BITS:   cfg_reg.total_bits   <= cfg_data;
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Pack the input ports into one item.
    assign s_item.cmd       = s_cmd;
    assign s_item.symbol    = s_symbol;
    assign s_item.frequency = s_frequency;
    assign s_item.code_byte = s_code_byte;

    // Front: accept and queue items so the input can run ahead of the walk.
    hfd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // Back: heap build, tree walk and result register.
    hfd_core #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .FREQ_WIDTH  (FREQ_WIDTH)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_symbol   (m_out_symbol),
        .m_last_of_item (m_last_of_item),
        .m_stream_done  (m_stream_done)
    );

endmodule

// File: rtl/hfd_front.sv
// ----------------------------------------------------------------------------
// Huffman tree decoder front end
// Accept items, tag them by command and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module hfd_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  hfd_pkg::item_t s_item,
    output logic           q_valid,
    input  logic           q_ready,
    output hfd_pkg::item_t q_item
);

    hfd_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    hfd_pkg::item_t tagged_item;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Clear the fields the command does not use.
    always_comb begin
        tagged_item = s_item;
        if (s_item.cmd == hfd_pkg::CMD_CODE) begin
            tagged_item.symbol    = '0;
            tagged_item.frequency = '0;
        end else begin
            tagged_item.code_byte = '0;
        end
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= tagged_item;
        end
    end

endmodule

// File: rtl/hfd_core.sv
// ----------------------------------------------------------------------------
// Huffman tree decoder core
// Heap build of the code tree and bit-by-bit tree walk with result register.
// ----------------------------------------------------------------------------
`include "huffman_tree_decoder_macros.svh"

module hfd_core #(
    parameter int MAX_SYMBOLS = 256,
    parameter int FREQ_WIDTH  = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  hfd_pkg::cfg_t  cfg,
    input  logic           q_valid,
    output logic           q_ready,
    input  hfd_pkg::item_t q_item,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_symbol,
    output logic           m_last_of_item,
    output logic           m_stream_done
);

    localparam int SYM_W  = $clog2(MAX_SYMBOLS);
    localparam int POS_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int NODE_W = $clog2(2 * MAX_SYMBOLS);
    localparam int W_W    = FREQ_WIDTH + 8;
    localparam int KEY_W  = W_W + NODE_W;
    localparam int BCNT_W = $clog2(hfd_pkg::BYTE_BITS + 1);

    // Memories: heap slots hold {weight, node}.
    logic [KEY_W-1:0]  heap_mem [MAX_SYMBOLS];
    logic [NODE_W-1:0] left_mem [MAX_SYMBOLS-1];
    logic [NODE_W-1:0] right_mem [MAX_SYMBOLS-1];
    logic [7:0]        sym_mem [MAX_SYMBOLS];

    logic              heap_we;
    logic [SYM_W-1:0]  heap_wa, heap_ra;
    logic [KEY_W-1:0]  heap_wd, heap_rd_reg;
    logic              kid_we;
    logic [SYM_W-1:0]  kid_wa, kid_ra;
    logic [NODE_W-1:0] kid_wl, kid_wr, left_rd_reg, right_rd_reg;
    logic              sym_we, sym_re;
    logic [SYM_W-1:0]  sym_wa, sym_ra;
    logic [7:0]        sym_wd, sym_rd_reg;

    hfd_pkg::state_t   state_reg, state_next;
    hfd_pkg::phase_t   phase_reg, phase_next;
    logic [POS_W-1:0]  heap_count_reg, heap_count_next;
    logic [NODE_W-1:0] nodes_used_reg, nodes_used_next;
    logic [NODE_W-1:0] leaf_total_reg, leaf_total_next;
    logic [NODE_W-1:0] root_reg, root_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [31:0]       bits_reg, bits_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  j_reg, j_next;
    logic              ctx_build_reg, ctx_build_next;
    logic              second_reg, second_next;
    logic [KEY_W-1:0]  top_reg, top_next;
    logic [KEY_W-1:0]  a_reg, a_next;
    logic [KEY_W-1:0]  last_reg, last_next;
    logic [KEY_W-1:0]  child_reg, child_next;
    logic [7:0]        byte_reg, byte_next;
    logic [BCNT_W-1:0] bcnt_reg, bcnt_next;
    logic              done_reg, done_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [7:0]        pend_sym_reg, pend_sym_next;
    logic              pend_done_reg, pend_done_next;
    logic              out_valid_reg;
    logic [7:0]        out_sym_reg;
    logic              out_last_reg, out_done_reg;

    logic              out_load, out_last, out_free;
    logic [9:0]        want;
    logic [POS_W:0]    li, ri;
    logic [W_W-1:0]    freq_w;
    logic [NODE_W-1:0] kid;

    assign m_valid        = out_valid_reg;
    assign m_out_symbol   = out_sym_reg;
    assign m_last_of_item = out_last_reg;
    assign m_stream_done  = out_done_reg;
    assign out_free       = !out_valid_reg || m_ready;

    assign li     = {pos_reg, 1'b0};
    assign ri     = li + (POS_W+1)'(1);
    assign freq_w = W_W'(q_item.frequency) & {{8{1'b0}}, {FREQ_WIDTH{1'b1}}};
    assign kid    = byte_reg[7] ? right_rd_reg : left_rd_reg;

    // Clamp the symbol count to one through MAX_SYMBOLS.
    always_comb begin
        if (cfg.symbol_count == 9'd0) begin
            want = 10'd1;
        end else if ({1'b0, cfg.symbol_count} > 10'(MAX_SYMBOLS)) begin
            want = 10'(MAX_SYMBOLS);
        end else begin
            want = {1'b0, cfg.symbol_count};
        end
    end

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        heap_count_next = heap_count_reg;
        nodes_used_next = nodes_used_reg;
        leaf_total_next = leaf_total_reg;
        root_next       = root_reg;
        cur_next        = cur_reg;
        bits_next       = bits_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        j_next          = j_reg;
        ctx_build_next  = ctx_build_reg;
        second_next     = second_reg;
        top_next        = top_reg;
        a_next          = a_reg;
        last_next       = last_reg;
        child_next      = child_reg;
        byte_next       = byte_reg;
        bcnt_next       = bcnt_reg;
        done_next       = done_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_done_next  = pend_done_reg;
        heap_we = 1'b0;
        heap_wa = '0;
        heap_wd = '0;
        heap_ra = '0;
        kid_we  = 1'b0;
        kid_wa  = '0;
        kid_wl  = '0;
        kid_wr  = '0;
        kid_ra  = '0;
        sym_we  = 1'b0;
        sym_wa  = '0;
        sym_wd  = '0;
        sym_re  = 1'b0;
        sym_ra  = '0;
        q_ready = 1'b0;
        out_load = 1'b0;
        out_last = 1'b0;

        case (state_reg)
            hfd_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_ready = 1'b1;
                    if (phase_reg == hfd_pkg::PH_LOAD) begin
                        if (q_item.cmd == hfd_pkg::CMD_ENTRY) begin
                            sym_we          = 1'b1;
                            sym_wa          = SYM_W'(nodes_used_reg);
                            sym_wd          = q_item.symbol;
                            key_next        = {freq_w, nodes_used_reg};
                            nodes_used_next = nodes_used_reg + NODE_W'(1);
                            pos_next        = heap_count_reg + POS_W'(1);
                            heap_count_next = heap_count_reg + POS_W'(1);
                            ctx_build_next  = 1'b0;
                            state_next      = hfd_pkg::ST_PUSH;
                        end
                    end else if (q_item.cmd == hfd_pkg::CMD_CODE) begin
                        byte_next  = q_item.code_byte;
                        bcnt_next  = '0;
                        state_next = hfd_pkg::ST_BIT;
                    end
                end
            end
            hfd_pkg::ST_PUSH: begin
                if (pos_reg > POS_W'(1)) begin
                    heap_ra    = SYM_W'((pos_reg >> 1) - POS_W'(1));
                    state_next = hfd_pkg::ST_PUSH_CMP;
                end else begin
                    heap_we    = 1'b1;
                    heap_wa    = SYM_W'(pos_reg - POS_W'(1));
                    heap_wd    = key_reg;
                    state_next = hfd_pkg::ST_PUSH_END;
                end
            end
            hfd_pkg::ST_PUSH_CMP: begin
                // Sift up only while strictly lighter than the parent.
                heap_we = 1'b1;
                heap_wa = SYM_W'(pos_reg - POS_W'(1));
                if (key_reg[KEY_W-1 -: W_W] < heap_rd_reg[KEY_W-1 -: W_W]) begin
                    heap_wd    = heap_rd_reg;
                    pos_next   = pos_reg >> 1;
                    state_next = hfd_pkg::ST_PUSH;
                end else begin
                    heap_wd    = key_reg;
                    state_next = hfd_pkg::ST_PUSH_END;
                end
            end
            hfd_pkg::ST_PUSH_END: begin
                if (ctx_build_reg) begin
                    state_next = hfd_pkg::ST_BUILD;
                end else if (10'(nodes_used_reg) >= want) begin
                    leaf_total_next = nodes_used_reg;
                    state_next      = hfd_pkg::ST_BUILD;
                end else begin
                    state_next = hfd_pkg::ST_IDLE;
                end
            end
            hfd_pkg::ST_BUILD: begin
                if (heap_count_reg == '0) begin
                    cur_next   = root_reg;
                    phase_next = hfd_pkg::PH_DECODE;
                    state_next = hfd_pkg::ST_IDLE;
                end else begin
                    second_next = 1'b0;
                    state_next  = hfd_pkg::ST_POP_TOP;
                end
            end
            hfd_pkg::ST_POP_TOP: begin
                heap_ra    = '0;
                state_next = hfd_pkg::ST_POP_LAST;
            end
            hfd_pkg::ST_POP_LAST: begin
                top_next        = heap_rd_reg;
                heap_ra         = SYM_W'(heap_count_reg - POS_W'(1));
                heap_count_next = heap_count_reg - POS_W'(1);
                state_next      = hfd_pkg::ST_POP_GOT;
            end
            hfd_pkg::ST_POP_GOT: begin
                last_next  = heap_rd_reg;
                pos_next   = POS_W'(1);
                state_next = hfd_pkg::ST_POP_CHK;
            end
            hfd_pkg::ST_POP_CHK: begin
                if (li <= {1'b0, heap_count_reg}) begin
                    heap_ra    = SYM_W'(li - (POS_W+1)'(1));
                    state_next = hfd_pkg::ST_POP_L;
                end else begin
                    heap_we    = 1'b1;
                    heap_wa    = SYM_W'(pos_reg - POS_W'(1));
                    heap_wd    = last_reg;
                    state_next = hfd_pkg::ST_POP_END;
                end
            end
            hfd_pkg::ST_POP_L: begin
                child_next = heap_rd_reg;
                j_next     = POS_W'(li);
                if (ri <= {1'b0, heap_count_reg}) begin
                    heap_ra    = SYM_W'(li);
                    state_next = hfd_pkg::ST_POP_R;
                end else begin
                    state_next = hfd_pkg::ST_POP_CMP;
                end
            end
            hfd_pkg::ST_POP_R: begin
                // Take the right child unless the left is strictly lighter.
                if (!(child_reg[KEY_W-1 -: W_W] < heap_rd_reg[KEY_W-1 -: W_W])) begin
                    child_next = heap_rd_reg;
                    j_next     = POS_W'(ri);
                end
                state_next = hfd_pkg::ST_POP_CMP;
            end
            hfd_pkg::ST_POP_CMP: begin
                heap_we = 1'b1;
                heap_wa = SYM_W'(pos_reg - POS_W'(1));
                if (last_reg[KEY_W-1 -: W_W] <= child_reg[KEY_W-1 -: W_W]) begin
                    heap_wd    = last_reg;
                    state_next = hfd_pkg::ST_POP_END;
                end else begin
                    heap_wd    = child_reg;
                    pos_next   = j_reg;
                    state_next = hfd_pkg::ST_POP_CHK;
                end
            end
            hfd_pkg::ST_POP_END: begin
                if (!second_reg) begin
                    if (heap_count_reg != '0) begin
                        a_next      = top_reg;
                        second_next = 1'b1;
                        state_next  = hfd_pkg::ST_POP_TOP;
                    end else begin
                        root_next  = top_reg[NODE_W-1:0];
                        state_next = hfd_pkg::ST_BUILD;
                    end
                end else begin
                    // Merge: first pop is the left child, second the right.
                    key_next = {a_reg[KEY_W-1 -: W_W] + top_reg[KEY_W-1 -: W_W],
                                nodes_used_reg};
                    kid_we          = 1'b1;
                    kid_wa          = SYM_W'(nodes_used_reg - leaf_total_reg);
                    kid_wl          = a_reg[NODE_W-1:0];
                    kid_wr          = top_reg[NODE_W-1:0];
                    nodes_used_next = nodes_used_reg + NODE_W'(1);
                    pos_next        = heap_count_reg + POS_W'(1);
                    heap_count_next = heap_count_reg + POS_W'(1);
                    ctx_build_next  = 1'b1;
                    state_next      = hfd_pkg::ST_PUSH;
                end
            end
            hfd_pkg::ST_BIT: begin
                if (bcnt_reg == BCNT_W'(hfd_pkg::BYTE_BITS) || bits_reg >= cfg.total_bits) begin
                    // Flush the held symbol as the last one of this byte.
                    if (!pend_valid_reg) begin
                        state_next = hfd_pkg::ST_IDLE;
                    end else if (out_free) begin
                        out_load        = 1'b1;
                        out_last        = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = hfd_pkg::ST_IDLE;
                    end
                end else if (root_reg >= leaf_total_reg) begin
                    kid_ra     = SYM_W'(cur_reg - leaf_total_reg);
                    state_next = hfd_pkg::ST_CHILD;
                end else begin
                    bits_next = bits_reg + 32'd1;
                    byte_next = {byte_reg[6:0], 1'b0};
                    bcnt_next = bcnt_reg + BCNT_W'(1);
                end
            end
            hfd_pkg::ST_CHILD: begin
                bits_next = bits_reg + 32'd1;
                done_next = (bits_reg + 32'd1) >= cfg.total_bits;
                byte_next = {byte_reg[6:0], 1'b0};
                bcnt_next = bcnt_reg + BCNT_W'(1);
                if (kid < leaf_total_reg) begin
                    sym_re     = 1'b1;
                    sym_ra     = SYM_W'(kid);
                    cur_next   = root_reg;
                    state_next = hfd_pkg::ST_SYM;
                end else begin
                    cur_next   = kid;
                    state_next = hfd_pkg::ST_BIT;
                end
            end
            hfd_pkg::ST_SYM: begin
                // Hold one symbol back so the last of the byte can be flagged.
                if (!pend_valid_reg || out_free) begin
                    out_load        = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_sym_next   = sym_rd_reg;
                    pend_done_next  = done_reg;
                    state_next      = hfd_pkg::ST_BIT;
                end
            end
            default: begin
                state_next = hfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= hfd_pkg::ST_IDLE;
            phase_reg      <= hfd_pkg::PH_LOAD;
            heap_count_reg <= '0;
            nodes_used_reg <= '0;
            leaf_total_reg <= '0;
            root_reg       <= '0;
            cur_reg        <= '0;
            bits_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            heap_count_reg <= heap_count_next;
            nodes_used_reg <= nodes_used_next;
            leaf_total_reg <= leaf_total_next;
            root_reg       <= root_next;
            cur_reg        <= cur_next;
            bits_reg       <= bits_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        pos_reg       <= pos_next;
        j_reg         <= j_next;
        ctx_build_reg <= ctx_build_next;
        second_reg    <= second_next;
        top_reg       <= top_next;
        a_reg         <= a_next;
        last_reg      <= last_next;
        child_reg     <= child_next;
        byte_reg      <= byte_next;
        bcnt_reg      <= bcnt_next;
        done_reg      <= done_next;
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
        if (out_load) begin
            out_sym_reg  <= pend_sym_reg;
            out_last_reg <= out_last;
            out_done_reg <= pend_done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (heap_we) begin
            heap_mem[heap_wa] <= heap_wd;
        end
        heap_rd_reg <= heap_mem[heap_ra];
    end

    always_ff @(posedge aclk) begin
        if (kid_we) begin
            left_mem[kid_wa]  <= kid_wl;
            right_mem[kid_wa] <= kid_wr;
        end
        left_rd_reg  <= left_mem[kid_ra];
        right_rd_reg <= right_mem[kid_ra];
    end

    always_ff @(posedge aclk) begin
        if (sym_we) begin
            sym_mem[sym_wa] <= sym_wd;
        end
        if (sym_re) begin
            sym_rd_reg <= sym_mem[sym_ra];
        end
    end

    `HFD_ASSERT_IMPL(a_heap_bound, aclk, aresetn, 1'b1, heap_count_reg <= POS_W'(MAX_SYMBOLS))
    `HFD_ASSERT_IMPL(a_decode_heap_empty, aclk, aresetn, phase_reg == hfd_pkg::PH_DECODE, heap_count_reg == '0)
    `HFD_ASSERT_IMPL(a_walk_needs_inner, aclk, aresetn, state_reg == hfd_pkg::ST_CHILD, root_reg >= leaf_total_reg)
    `HFD_ASSERT_NEXT(a_load_needs_room, aclk, aresetn, out_load, out_valid_reg)

endmodule

// File: test/hfd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Huffman tree decoder checker
// Watches the configuration, input and result channels, keeps its own copy
// of the heap, the code tree and the decode walk, and compares every result
// item with the oldest predicted symbol.
// ----------------------------------------------------------------------------
module hfd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_symbol,
    input  logic [31:0] s_frequency,
    input  logic [7:0]  s_code_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_symbol,
    input  logic        m_last_of_item,
    input  logic        m_stream_done,
    output int          pending,
    output int          fails
);

    localparam int LEAF_MAX  = 256;
    localparam int NODE_MAX  = 2 * LEAF_MAX - 1;
    localparam int INNER_MAX = LEAF_MAX - 1;

    typedef struct packed {
        logic [7:0] sym;
        logic       last;
        logic       done;
    } decoded_t;

    decoded_t   symbols_due[$];

    bit [39:0]  weight[NODE_MAX];
    bit [8:0]   heap[LEAF_MAX];
    bit [8:0]   left_of[INNER_MAX];
    bit [8:0]   right_of[INNER_MAX];
    bit [7:0]   leaf_sym[LEAF_MAX];
    int         heap_len, nodes, root, walk, leaves;
    bit [31:0]  bits_seen;
    hfd_pkg::phase_t phase;
    bit [8:0]   count_reg;
    bit [31:0]  bits_limit;

    function automatic bit [39:0] wt(int n);
        return (n < NODE_MAX) ? weight[n] : 40'd0;
    endfunction

    function automatic int slot(int pos);
        return (pos >= 1 && pos <= LEAF_MAX) ? int'(heap[pos-1]) : 0;
    endfunction

    function automatic void put(int pos, int n);
        if (pos >= 1 && pos <= LEAF_MAX)
            heap[pos-1] = n[8:0];
    endfunction

    // Sift up only while strictly lighter than the parent.
    function automatic void heap_insert(int n);
        int i;
        if (heap_len >= LEAF_MAX)
            return;
        heap_len++;
        i = heap_len;
        while (i > 1 && wt(n) < wt(slot(i / 2))) begin
            put(i, slot(i / 2));
            i = i / 2;
        end
        put(i, n);
    endfunction

    function automatic int heap_take_min();
        int top, tail, i, j;
        if (heap_len == 0)
            return 0;
        top = slot(1);
        tail = slot(heap_len);
        heap_len--;
        i = 1;
        while (2 * i <= heap_len) begin
            j = 2 * i;
            if (j + 1 <= heap_len && !(wt(slot(j)) < wt(slot(j + 1))))
                j = j + 1;
            if (wt(tail) <= wt(slot(j)))
                break;
            put(i, slot(j));
            i = j;
        end
        put(i, tail);
        return top;
    endfunction

    function automatic void merge_tree();
        int a, b, k, inner;
        leaves = nodes;
        while (heap_len > 0) begin
            a = heap_take_min();
            if (heap_len > 0) begin
                b = heap_take_min();
                k = nodes;
                inner = k - leaves;
                if (k < NODE_MAX && inner < INNER_MAX) begin
                    weight[k] = wt(a) + wt(b);
                    left_of[inner] = a[8:0];
                    right_of[inner] = b[8:0];
                    nodes++;
                    heap_insert(k);
                end
            end else begin
                root = a;
            end
        end
        walk = root;
        phase = hfd_pkg::PH_DECODE;
    endfunction

    function automatic void clear_state();
        count_reg = 9'd1;
        bits_limit = '0;
        heap_len = 0;
        nodes = 0;
        root = 0;
        walk = 0;
        leaves = 0;
        bits_seen = '0;
        phase = hfd_pkg::PH_LOAD;
        symbols_due.delete();
    endfunction

    function automatic void take_item();
        int want, inner, first;
        bit [7:0] code;
        first = symbols_due.size();
        if (phase == hfd_pkg::PH_LOAD) begin
            if (s_cmd != hfd_pkg::CMD_ENTRY)
                return;
            want = count_reg;
            if (want == 0) want = 1;
            if (want > LEAF_MAX) want = LEAF_MAX;
            if (nodes < LEAF_MAX) begin
                weight[nodes] = {8'd0, s_frequency};
                leaf_sym[nodes] = s_symbol;
                nodes++;
                heap_insert(nodes - 1);
            end
            if (nodes >= want)
                merge_tree();
            return;
        end
        if (s_cmd != hfd_pkg::CMD_CODE)
            return;
        code = s_code_byte;
        for (int k = 0; k < hfd_pkg::BYTE_BITS; k++) begin
            if (bits_seen >= bits_limit)
                break;
            if (root >= leaves) begin
                inner = walk - leaves;
                if (walk < leaves || inner >= INNER_MAX) begin
                    walk = root;
                    inner = walk - leaves;
                    if (inner >= INNER_MAX) inner = 0;
                end
                walk = code[7] ? int'(right_of[inner]) : int'(left_of[inner]);
            end
            bits_seen++;
            if (root >= leaves && walk < leaves) begin
                symbols_due.push_back('{sym: (walk < LEAF_MAX) ? leaf_sym[walk] : 8'd0,
                                        last: 1'b0,
                                        done: bits_seen >= bits_limit});
                walk = root;
            end
            code = code << 1;
        end
        if (symbols_due.size() > first)
            symbols_due[symbols_due.size() - 1].last = 1'b1;
    endfunction

    initial begin
        fails = 0;
        pending = 0;
        clear_state();
    end

    always @(posedge aclk) begin
        decoded_t got, due;
        if (!aresetn) begin
            clear_state();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == hfd_pkg::CFG_SYMBOL_COUNT)
                    count_reg = cfg_data[8:0];
                else
                    bits_limit = cfg_data;
            end
            if (s_valid && s_ready)
                take_item();
            if (m_valid && m_ready) begin
                got = '{sym: m_out_symbol, last: m_last_of_item, done: m_stream_done};
                if (symbols_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected symbol %h last %b done %b",
                                 $realtime, got.sym, got.last, got.done);
                end else begin
                    due = symbols_due.pop_front();
                    if (got !== due) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: expected sym %h last %b done %b, got %h %b %b",
                                     $realtime, due.sym, due.last, due.done,
                                     got.sym, got.last, got.done);
                    end
                end
            end
        end
        pending <= symbols_due.size();
    end

endmodule

// File: test/tb_huffman_tree_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Huffman tree decoder testbench
// Loads one symbol table (lowering the count mid-load to trigger the build),
// then walks directed and random code bytes under several bit limits, with
// random gaps on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_huffman_tree_decoder;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = hfd_pkg::CFG_SYMBOL_COUNT;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = hfd_pkg::CMD_ENTRY;
    logic [7:0]  s_symbol = '0;
    logic [31:0] s_frequency = '0;
    logic [7:0]  s_code_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_symbol;
    logic        m_last_of_item;
    logic        m_stream_done;
    int          pending;
    int          fails;

    // no_gaps: suppress random idling on both sides for a stretch
    // hold_sink: ask the result side for one long back-pressure stretch
    bit          no_gaps = 1'b0;
    bit          hold_sink = 1'b0;
    int          sent_codes = 0;

    always #6 aclk = ~aclk;

    huffman_tree_decoder u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_symbol(s_symbol), .s_frequency(s_frequency), .s_code_byte(s_code_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_symbol(m_out_symbol),
        .m_last_of_item(m_last_of_item), .m_stream_done(m_stream_done)
    );

    hfd_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_symbol(s_symbol), .s_frequency(s_frequency), .s_code_byte(s_code_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_symbol(m_out_symbol),
        .m_last_of_item(m_last_of_item), .m_stream_done(m_stream_done),
        .pending(pending), .fails(fails)
    );

    // Offer one item; idle first at random, then hold valid until accepted.
    // Valid stays high after acceptance so back-to-back items never toggle it.
    task automatic offer(logic cmd, logic [7:0] sym, logic [31:0] freq, logic [7:0] code);
        while (!no_gaps && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_symbol    <= sym;
        s_frequency <= freq;
        s_code_byte <= code;
        do @(posedge aclk); while (!s_ready);
        if (cmd == hfd_pkg::CMD_CODE)
            sent_codes++;
    endtask

    // Drain: drop valid, wait for every predicted symbol, then let any
    // resultless work (heap build, counted bits) finish before touching config.
    task automatic drain();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (2000) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, plus one long counted hold on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_sink = 1'b0;
            end
            m_ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 32);
        end
    end

    // Watchdog.
    initial begin
        #6000000;
        $display("huffman_tree_decoder: mismatch");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Count of zero then an out-of-range count: the latter loads up to 256.
        write_reg(hfd_pkg::CFG_SYMBOL_COUNT, 32'd0);
        write_reg(hfd_pkg::CFG_SYMBOL_COUNT, 32'd511);
        write_reg(hfd_pkg::CFG_TOTAL_BITS, 32'd0);

        // Eleven leaves: field extremes, equal weights, a zero weight.
        offer(hfd_pkg::CMD_ENTRY, 8'h00, 32'h0000_0000, 8'h00);
        offer(hfd_pkg::CMD_ENTRY, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
        offer(hfd_pkg::CMD_CODE,  8'h12, 32'h0000_0001, 8'hA5);   // ignored while loading
        offer(hfd_pkg::CMD_ENTRY, 8'h41, 32'hFFFF_FFFF, 8'h00);
        offer(hfd_pkg::CMD_ENTRY, 8'h42, 32'd5, 8'h00);
        offer(hfd_pkg::CMD_ENTRY, 8'h43, 32'd5, 8'h00);
        offer(hfd_pkg::CMD_ENTRY, 8'h44, 32'd5, 8'h00);
        offer(hfd_pkg::CMD_ENTRY, 8'h45, 32'd1, 8'h00);
        for (int i = 0; i < 4; i++)
            offer(hfd_pkg::CMD_ENTRY, 8'($urandom), $urandom_range(40), 8'($urandom));
        drain();

        // Lower the count below what is loaded: the next entry builds the tree.
        write_reg(hfd_pkg::CFG_SYMBOL_COUNT, 32'd2);
        offer(hfd_pkg::CMD_ENTRY, 8'h80, 32'h8000_0000, 8'h00);
        offer(hfd_pkg::CMD_ENTRY, 8'h81, 32'd7, 8'h00);            // ignored after load
        drain();

        // Zero bit budget: bytes yield nothing.
        offer(hfd_pkg::CMD_CODE, 8'h00, 32'h0, 8'hFF);
        offer(hfd_pkg::CMD_CODE, 8'h00, 32'h0, 8'h00);
        drain();

        // Small budget ends mid-byte, then the stream stays finished.
        write_reg(hfd_pkg::CFG_TOTAL_BITS, 32'd21);
        offer(hfd_pkg::CMD_CODE, 8'h00, 32'h0, 8'h00);
        offer(hfd_pkg::CMD_CODE, 8'h00, 32'h0, 8'hFF);
        offer(hfd_pkg::CMD_CODE, 8'h00, 32'h0, 8'hAA);
        offer(hfd_pkg::CMD_CODE, 8'h00, 32'h0, 8'h55);
        drain();

        // Raise the budget to the maximum: decoding resumes.
        write_reg(hfd_pkg::CFG_TOTAL_BITS, 32'hFFFF_FFFF);
        offer(hfd_pkg::CMD_CODE, 8'h00, 32'h0, 8'h0F);

        // Random part: mostly code bytes, some stray entries.
        for (int n = 0; n < 200; n++) begin
            if (n == 40)
                hold_sink = 1'b1;              // sink backs up, source keeps offering
            no_gaps = (n >= 100 && n < 140);
            if ($urandom_range(9) == 0)
                offer(hfd_pkg::CMD_ENTRY, 8'($urandom), $urandom, 8'($urandom));
            else
                offer(hfd_pkg::CMD_CODE, 8'($urandom), $urandom, 8'($urandom));
            if (n == 150)
                drain();                       // source pauses until all results are in
        end
        no_gaps = 1'b0;
        drain();

        $display("Covered one %0d-leaf tree built after a mid-load count change,", 12);
        $display("%0d code bytes under zero, short and maximum bit budgets.", sent_codes);
        if (fails == 0 && pending == 0) begin
            $display("huffman_tree_decoder: match");
        end else begin
            $display("huffman_tree_decoder: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/hfd_pkg.sv
rtl/hfd_front.sv
rtl/hfd_core.sv
rtl/huffman_tree_decoder.sv
test/hfd_checker.sv
test/tb_huffman_tree_decoder.sv
